FILE: design/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

  localparam int COORD_W     = 12;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int FRAC_W      = 16;
  localparam int DIM_W       = 9;
  localparam int RATE_W      = 20;
  localparam int POS_W       = COORD_W + RATE_W;
  localparam int IPOS_W      = POS_W - FRAC_W;
  localparam int HSUM_W      = FRAC_W + CH_W;
  localparam int VSUM_W      = 2 * FRAC_W + CH_W;
  localparam int ADDR_CALC_W = 25;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int NUM_CH      = 3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RATE   = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]  src_width;
    logic [DIM_W-1:0]  src_height;
    logic [RATE_W-1:0] inv_rate;
  } cfg_t;

  // four neighbors of one request, handed from the fetch side to the blend side
  typedef struct packed {
    logic              vld;
    logic              in_bounds;
    logic [FRAC_W-1:0] dx;
    logic [FRAC_W-1:0] dy;
    logic [PIX_W-1:0]  p00;
    logic [PIX_W-1:0]  p01;
    logic [PIX_W-1:0]  p10;
    logic [PIX_W-1:0]  p11;
  } quad_t;

endpackage

FILE: design/bis_in_if.sv
`timescale 1ns / 1ps

interface bis_in_if import bis_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic [CH_W-1:0]    in_red;
  logic [CH_W-1:0]    in_green;
  logic [CH_W-1:0]    in_blue;

  modport source (output valid, opcode, pix_x, pix_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, opcode, pix_x, pix_y, in_red, in_green, in_blue,
                output ready);
endinterface

FILE: design/bis_out_if.sv
`timescale 1ns / 1ps

interface bis_out_if import bis_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            inside_res;

  modport source (output valid, out_red, out_green, out_blue, inside_res,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, inside_res,
                output ready);
endinterface

FILE: design/bis_ram.sv
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bis_fetch.sv
`timescale 1ns / 1ps

module bis_fetch import bis_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  bis_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     blend_busy,
  output quad_t    quad
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [ADDR_CALC_W-1:0] ROW_OFS = ADDR_CALC_W'(MAX_WIDTH);
  localparam logic [IPOS_W:0]        W_MAX   = (IPOS_W + 1)'(MAX_WIDTH);
  localparam logic [IPOS_W:0]        H_MAX   = (IPOS_W + 1)'(MAX_HEIGHT);

  typedef enum logic [1:0] {STEP_P00, STEP_P01, STEP_P10, STEP_P11} step_t;

  // command stage
  logic               cmd_v_r, cmd_v_nxt;
  logic               cmd_op_r;
  logic [COORD_W-1:0] cmd_px_r, cmd_py_r;
  logic [PIX_W-1:0]   cmd_pix_r;
  logic [POS_W-1:0]   cmd_xa_r, cmd_ya_r;
  step_t              step_r, step_nxt;

  // read return tracking
  logic               arr_v_r, arr_v_nxt;
  step_t              arr_step_r;
  logic               arr_inside_r;
  logic [FRAC_W-1:0]  arr_dx_r, arr_dy_r;
  logic [PIX_W-1:0]   p00_r, p01_r, p10_r;

  logic [IPOS_W-1:0]      ix, iy;
  logic [FRAC_W-1:0]      dx, dy;
  logic [IPOS_W:0]        w_eff, h_eff;
  logic                   in_bounds;
  logic                   ld_ok;
  logic [ADDR_CALC_W-1:0] ld_addr, rd_base, rd_ofs, rd_addr;
  logic                   last_ok;
  logic                   issue, issue_read, cmd_done, accept;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [PIX_W-1:0]       mem_rdata;

  assign ix = cmd_xa_r[POS_W-1:FRAC_W];
  assign iy = cmd_ya_r[POS_W-1:FRAC_W];
  assign dx = cmd_xa_r[FRAC_W-1:0];
  assign dy = cmd_ya_r[FRAC_W-1:0];

  always_comb begin
    w_eff = (IPOS_W + 1)'(cfg.src_width);
    h_eff = (IPOS_W + 1)'(cfg.src_height);
    if (w_eff > W_MAX) begin
      w_eff = W_MAX;
    end
    if (h_eff > H_MAX) begin
      h_eff = H_MAX;
    end
  end

  assign in_bounds = (({1'b0, ix} + 1'b1) < w_eff) && (({1'b0, iy} + 1'b1) < h_eff);

  assign ld_ok   = ({1'b0, cmd_px_r} < (COORD_W + 1)'(MAX_WIDTH)) &&
                   ({1'b0, cmd_py_r} < (COORD_W + 1)'(MAX_HEIGHT));
  assign ld_addr = ADDR_CALC_W'(cmd_py_r) * ROW_OFS + ADDR_CALC_W'(cmd_px_r);
  assign rd_base = ADDR_CALC_W'(iy[COORD_W-1:0]) * ROW_OFS
                 + ADDR_CALC_W'(ix[COORD_W-1:0]);

  always_comb begin
    unique case (step_r)
      STEP_P00: rd_ofs = '0;
      STEP_P01: rd_ofs = ADDR_CALC_W'(1);
      STEP_P10: rd_ofs = ROW_OFS;
      STEP_P11: rd_ofs = ROW_OFS + ADDR_CALC_W'(1);
      default:  rd_ofs = '0;
    endcase
  end

  assign rd_addr = rd_base + rd_ofs;

  // the closing beat of a request must find the blend stage free and not about to fill
  assign last_ok = !blend_busy && !(arr_v_r && (arr_step_r == STEP_P11));

  always_comb begin
    issue      = 1'b0;
    issue_read = 1'b0;
    cmd_done   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = AW'(rd_addr);
    if (cmd_v_r) begin
      if (cmd_op_r == OP_LOAD) begin
        mem_we   = ld_ok;
        mem_addr = AW'(ld_addr);
        cmd_done = 1'b1;
      end else if (!in_bounds) begin
        issue    = last_ok;
        cmd_done = last_ok;
      end else if (step_r != STEP_P11) begin
        issue      = 1'b1;
        issue_read = 1'b1;
      end else begin
        issue      = last_ok;
        issue_read = last_ok;
        cmd_done   = last_ok;
      end
    end
  end

  assign in_ch.ready = !cmd_v_r || cmd_done;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd_v_nxt = cmd_v_r;
    if (accept) begin
      cmd_v_nxt = 1'b1;
    end else if (cmd_done) begin
      cmd_v_nxt = 1'b0;
    end
    step_nxt = step_r;
    if (cmd_done) begin
      step_nxt = STEP_P00;
    end else if (issue_read) begin
      step_nxt = step_t'(step_r + 2'd1);
    end
    arr_v_nxt = issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
      step_r  <= STEP_P00;
      arr_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
      step_r  <= step_nxt;
      arr_v_r <= arr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op_r  <= in_ch.opcode;
      cmd_px_r  <= in_ch.pix_x;
      cmd_py_r  <= in_ch.pix_y;
      cmd_pix_r <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
      cmd_xa_r  <= POS_W'(in_ch.pix_x) * POS_W'(cfg.inv_rate);
      cmd_ya_r  <= POS_W'(in_ch.pix_y) * POS_W'(cfg.inv_rate);
    end
    if (issue) begin
      // an outside request takes a single closing beat with no read
      arr_step_r   <= in_bounds ? step_r : STEP_P11;
      arr_inside_r <= in_bounds;
      arr_dx_r     <= dx;
      arr_dy_r     <= dy;
    end
    if (arr_v_r) begin
      unique case (arr_step_r)
        STEP_P00: p00_r <= mem_rdata;
        STEP_P01: p01_r <= mem_rdata;
        STEP_P10: p10_r <= mem_rdata;
        default:  ;
      endcase
    end
  end

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (cmd_pix_r),
    .rdata (mem_rdata)
  );

  assign quad.vld       = arr_v_r && (arr_step_r == STEP_P11);
  assign quad.in_bounds = arr_inside_r;
  assign quad.dx        = arr_dx_r;
  assign quad.dy        = arr_dy_r;
  assign quad.p00       = p00_r;
  assign quad.p01       = p01_r;
  assign quad.p10       = p10_r;
  assign quad.p11       = mem_rdata;

endmodule

FILE: design/bis_blend.sv
`timescale 1ns / 1ps

module bis_blend import bis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  quad_t      quad,
  output logic       blend_busy,
  bis_out_if.source  out_ch
);

  // horizontal stage
  logic              b1_v_r, b1_v_nxt;
  logic              b1_inside_r;
  logic [FRAC_W-1:0] b1_dy_r;
  logic [HSUM_W-1:0] t0_r [NUM_CH];
  logic [HSUM_W-1:0] t1_r [NUM_CH];

  // output register
  logic              out_v_r, out_v_nxt;
  logic              out_inside_r;
  logic [CH_W-1:0]   out_ch_r [NUM_CH];

  logic              b1_adv;
  logic [HSUM_W-1:0] t0_c [NUM_CH];
  logic [HSUM_W-1:0] t1_c [NUM_CH];
  logic [CH_W-1:0]   v_c  [NUM_CH];

  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int c);
    return p[PIX_W-1-CH_W*c -: CH_W];
  endfunction

  function automatic logic [HSUM_W-1:0] hmix(input logic [FRAC_W-1:0] f,
                                             input logic [CH_W-1:0]   a,
                                             input logic [CH_W-1:0]   b);
    logic [FRAC_W:0]   wa;
    logic [HSUM_W:0]   s;
    wa = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(f);
    s  = (HSUM_W + 1)'(wa) * (HSUM_W + 1)'(a) + (HSUM_W + 1)'(f) * (HSUM_W + 1)'(b);
    return s[HSUM_W-1:0];
  endfunction

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      t0_c[c] = hmix(quad.dx, chan(quad.p00, c), chan(quad.p01, c));
      t1_c[c] = hmix(quad.dx, chan(quad.p10, c), chan(quad.p11, c));
    end
  end

  always_comb begin
    logic [FRAC_W:0]   wy;
    logic [VSUM_W-1:0] s;
    wy = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(b1_dy_r);
    for (int c = 0; c < NUM_CH; c++) begin
      s      = VSUM_W'(wy) * VSUM_W'(t0_r[c]) + VSUM_W'(b1_dy_r) * VSUM_W'(t1_r[c]);
      v_c[c] = b1_inside_r ? s[VSUM_W-1 -: CH_W] : '0;
    end
  end

  assign b1_adv     = b1_v_r && (!out_v_r || out_ch.ready);
  assign blend_busy = b1_v_r;

  always_comb begin
    b1_v_nxt = b1_v_r;
    if (quad.vld) begin
      b1_v_nxt = 1'b1;
    end else if (b1_adv) begin
      b1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (b1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (quad.vld) begin
      b1_inside_r <= quad.in_bounds;
      b1_dy_r     <= quad.dy;
      t0_r        <= t0_c;
      t1_r        <= t1_c;
    end
    if (b1_adv) begin
      out_inside_r <= b1_inside_r;
      out_ch_r     <= v_c;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_red    = out_ch_r[0];
  assign out_ch.out_green  = out_ch_r[1];
  assign out_ch.out_blue   = out_ch_r[2];
  assign out_ch.inside_res = out_inside_r;

endmodule

FILE: design/bilinear_image_scaler_top.sv
// Load beat: accepted one per cycle while no request waits in the command stage;
// written to the frame store the cycle after. Request beat: four neighbor reads on
// the single frame store port, then the horizontal stage and output register; with
// a neighbor outside, no read. A new request is taken once the last one has issued
// its closing beat, which waits for a free blend stage. Reset clears the pipeline,
// sets width 256, height 256, inv_rate 1.0; the frame store is not cleared.
`timescale 1ns / 1ps

module bilinear_image_scaler_top import bis_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bis_in_if.sink                in_ch,
  bis_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]  src_width_r, src_width_nxt;
  logic [DIM_W-1:0]  src_height_r, src_height_nxt;
  logic [RATE_W-1:0] inv_rate_r, inv_rate_nxt;
  cfg_t              cfg;
  quad_t             quad;
  logic              blend_busy;

  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    inv_rate_nxt   = inv_rate_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_nxt  = cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_nxt = cfg_data[DIM_W-1:0];
        CFG_INV_RATE:   inv_rate_nxt   = cfg_data[RATE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(256);
      src_height_r <= DIM_W'(256);
      inv_rate_r   <= RATE_W'(1 << FRAC_W);
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      inv_rate_r   <= inv_rate_nxt;
    end
  end

  assign cfg.src_width  = src_width_r;
  assign cfg.src_height = src_height_r;
  assign cfg.inv_rate   = inv_rate_r;

  bis_fetch #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_fetch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .blend_busy (blend_busy),
    .quad       (quad)
  );

  bis_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad       (quad),
    .blend_busy (blend_busy),
    .out_ch     (out_ch)
  );

endmodule
